// ===== design/tccb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccb_pkg
// Shared types and constants for the text console cell buffer.
// ----------------------------------------------------------------------------
package tccb_pkg;

  localparam int unsigned MaxCols  = 128;
  localparam int unsigned MaxRows  = 64;
  localparam int unsigned ColW     = $clog2(MaxCols);
  localparam int unsigned RowW     = $clog2(MaxRows);
  localparam int unsigned AddrW    = ColW + RowW;
  localparam int unsigned Depth    = MaxCols * MaxRows;

  localparam int unsigned ModeW    = 3;
  localparam int unsigned CharW    = 8;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned PosColW  = 8;
  localparam int unsigned PosRowW  = 7;
  localparam int unsigned OutColW  = 7;
  localparam int unsigned OutRowW  = 6;
  localparam int unsigned CfgColsW = 8;
  localparam int unsigned CfgRowsW = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgColsW-1:0] ColsReset = CfgColsW'(80);
  localparam logic [CfgRowsW-1:0] RowsReset = CfgRowsW'(25);

  localparam logic [CharW-1:0] NewlineCode = CharW'(10);
  localparam logic [CharW-1:0] BlankCode   = CharW'(32);

  typedef enum logic [ModeW-1:0] {
    MODE_PRINT = 3'd0,
    MODE_SET   = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_FILL  = 3'd3,
    MODE_READ  = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    WK_NEWLINE,
    WK_SCROLL,
    WK_FILL
  } walk_kind_e;

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic [ColorW-1:0] color;
  } cell_t;

endpackage

// ===== design/text_console_cell_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_buffer
// Text console over a single-port character-cell store with row scrolling.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 8192-entry cell store to zero, one cell
// per cycle, and accepts no item until the sweep is done. Every store access
// goes through one single-port memory, one cell per cycle, so an item that
// walks cells takes longer: a print that wraps past the last row blanks the
// new last row; a newline blanks from the cursor column to the row end, and
// the new last row too when it scrolls; a fill writes all rows * cols cells.
// A result register lets the next item be accepted while the previous result
// is still waiting.
module text_console_cell_buffer (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tccb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tccb_pkg::CfgDataW-1:0]  cfg_data_i,

  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tccb_pkg::ModeW-1:0]     mode_i,
  input  logic [tccb_pkg::CharW-1:0]     char_code_i,
  input  logic [tccb_pkg::ColorW-1:0]    color_rgb_i,
  input  logic signed [tccb_pkg::PosColW-1:0] pos_col_i,
  input  logic signed [tccb_pkg::PosRowW-1:0] pos_row_i,

  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tccb_pkg::OutColW-1:0]   cursor_col_o,
  output logic [tccb_pkg::OutRowW-1:0]   cursor_row_o,
  output logic [tccb_pkg::CharW-1:0]     read_char_o,
  output logic [tccb_pkg::ColorW-1:0]    read_color_o,
  output logic                           read_valid_o
);
  import tccb_pkg::*;

  state_e                state_q, state_d;

  mode_e                 mode_q;
  logic [CharW-1:0]      ch_q;
  logic [ColorW-1:0]     color_q;
  logic signed [PosColW-1:0] pc_q;
  logic signed [PosRowW-1:0] pr_q;

  logic [CfgColsW-1:0]   cols_q, cols_d;
  logic [CfgRowsW-1:0]   rows_q, rows_d;
  logic [ColW-1:0]       cursor_col_q, cursor_col_d;
  logic [RowW-1:0]       cursor_row_q, cursor_row_d;
  logic [RowW-1:0]       offset_q, offset_d;

  logic [ColW-1:0]       walk_col_q, walk_col_d;
  logic [RowW-1:0]       walk_row_q, walk_row_d;
  walk_kind_e            walk_kind_q, walk_kind_d;
  logic [CharW-1:0]      walk_ch_q, walk_ch_d;

  logic [AddrW-1:0]      clr_cnt_q, clr_cnt_d;
  logic                  rd_ok_q, rd_ok_d;
  cell_t                 rd_data_q;

  logic                  out_valid_q, out_valid_d;
  logic [OutColW-1:0]    out_col_q;
  logic [OutRowW-1:0]    out_row_q;
  logic [CharW-1:0]      out_ch_q;
  logic [ColorW-1:0]     out_color_q;
  logic                  out_rd_ok_q;

  cell_t                 mem_q [Depth];
  logic                  mem_we, mem_re;
  logic [AddrW-1:0]      mem_addr;
  cell_t                 mem_wdata;

  logic [CfgColsW-1:0]   cols_a;
  logic [CfgRowsW-1:0]   rows_a;
  logic signed [PosColW:0] pc_adj;
  logic signed [PosRowW:0] pr_adj;
  logic                  pos_ok;
  logic [ColW-1:0]       acc_col;
  logic [RowW-1:0]       acc_row;
  logic [RowW:0]         phys_sum, phys_row;
  logic [ColW:0]         col_inc, walk_col_inc;
  logic [RowW:0]         row_inc, walk_row_inc, off_inc;
  logic [RowW-1:0]       next_off, last_row;
  logic                  accept, slot_free, out_load, cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_FINISH) && slot_free);
  assign accept      = in_valid_i && in_ready_o;

  // Active geometry, clamped to the store size
  always_comb begin
    if (cols_q == '0) begin
      cols_a = CfgColsW'(1);
    end else if (cols_q > CfgColsW'(MaxCols)) begin
      cols_a = CfgColsW'(MaxCols);
    end else begin
      cols_a = cols_q;
    end
    if (rows_q == '0) begin
      rows_a = CfgRowsW'(1);
    end else if (rows_q > CfgRowsW'(MaxRows)) begin
      rows_a = CfgRowsW'(MaxRows);
    end else begin
      rows_a = rows_q;
    end
  end

  // Position resolve: negative counts from the far edge
  always_comb begin
    pc_adj = {pc_q[PosColW-1], pc_q};
    pr_adj = {pr_q[PosRowW-1], pr_q};
    if (pc_q[PosColW-1]) begin
      pc_adj = pc_adj + $signed({1'b0, cols_a});
    end
    if (pr_q[PosRowW-1]) begin
      pr_adj = pr_adj + $signed({1'b0, rows_a});
    end
    pos_ok = !pc_adj[PosColW] && (pc_adj[PosColW-1:0] < cols_a) &&
             !pr_adj[PosRowW] && (pr_adj[PosRowW-1:0] < rows_a);
  end

  assign col_inc      = {1'b0, cursor_col_q} + (ColW+1)'(1);
  assign row_inc      = {1'b0, cursor_row_q} + (RowW+1)'(1);
  assign walk_col_inc = {1'b0, walk_col_q} + (ColW+1)'(1);
  assign walk_row_inc = {1'b0, walk_row_q} + (RowW+1)'(1);
  assign off_inc      = {1'b0, offset_q} + (RowW+1)'(1);
  assign next_off     = (off_inc >= rows_a) ? '0 : off_inc[RowW-1:0];
  assign last_row     = RowW'(rows_a - CfgRowsW'(1));

  // Displayed row to physical row through the circular offset
  assign phys_sum = {1'b0, offset_q} + {1'b0, acc_row};
  assign phys_row = (phys_sum >= rows_a) ? phys_sum - rows_a : phys_sum;
  assign mem_addr = (state_q == ST_CLEAR) ? clr_cnt_q : {phys_row[RowW-1:0], acc_col};

  always_comb begin
    state_d      = state_q;
    cols_d       = cols_q;
    rows_d       = rows_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    offset_d     = offset_q;
    walk_col_d   = walk_col_q;
    walk_row_d   = walk_row_q;
    walk_kind_d  = walk_kind_q;
    walk_ch_d    = walk_ch_q;
    clr_cnt_d    = clr_cnt_q;
    rd_ok_d      = rd_ok_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wdata    = '{ch: ch_q, color: color_q};
    acc_col      = cursor_col_q;
    acc_row      = cursor_row_q;
    out_load     = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_FINISH;
        rd_ok_d = 1'b0;
        case (mode_q)
          MODE_PRINT: begin
            walk_ch_d = BlankCode;
            if (ch_q == NewlineCode) begin
              walk_col_d  = cursor_col_q;
              walk_row_d  = cursor_row_q;
              walk_kind_d = WK_NEWLINE;
              state_d     = ST_WALK;
            end else begin
              mem_we = ({1'b0, cursor_col_q} < cols_a) && ({1'b0, cursor_row_q} < rows_a);
              if (col_inc >= cols_a) begin
                cursor_col_d = '0;
                if (row_inc >= rows_a) begin
                  offset_d     = next_off;
                  cursor_row_d = last_row;
                  walk_col_d   = '0;
                  walk_row_d   = last_row;
                  walk_kind_d  = WK_SCROLL;
                  state_d      = ST_WALK;
                end else begin
                  cursor_row_d = row_inc[RowW-1:0];
                end
              end else begin
                cursor_col_d = col_inc[ColW-1:0];
              end
            end
          end
          MODE_SET: begin
            if (pos_ok) begin
              cursor_col_d = pc_adj[ColW-1:0];
              cursor_row_d = pr_adj[RowW-1:0];
            end
          end
          MODE_WRITE: begin
            acc_col = pc_adj[ColW-1:0];
            acc_row = pr_adj[RowW-1:0];
            mem_we  = pos_ok;
          end
          MODE_FILL: begin
            walk_col_d   = '0;
            walk_row_d   = '0;
            walk_kind_d  = WK_FILL;
            walk_ch_d    = ch_q;
            cursor_col_d = '0;
            cursor_row_d = '0;
            state_d      = ST_WALK;
          end
          MODE_READ: begin
            acc_col = pc_adj[ColW-1:0];
            acc_row = pr_adj[RowW-1:0];
            mem_re  = pos_ok;
            rd_ok_d = pos_ok;
          end
          default: begin
          end
        endcase
      end
      ST_WALK: begin
        acc_col   = walk_col_q;
        acc_row   = walk_row_q;
        mem_wdata = '{ch: walk_ch_q, color: color_q};
        mem_we    = ({1'b0, walk_col_q} < cols_a) && ({1'b0, walk_row_q} < rows_a);
        if (walk_col_inc < cols_a) begin
          walk_col_d = walk_col_inc[ColW-1:0];
        end else begin
          walk_col_d = '0;
          case (walk_kind_q)
            WK_FILL: begin
              if (walk_row_inc < rows_a) begin
                walk_row_d = walk_row_inc[RowW-1:0];
              end else begin
                state_d = ST_FINISH;
              end
            end
            WK_NEWLINE: begin
              cursor_col_d = '0;
              if (row_inc >= rows_a) begin
                offset_d     = next_off;
                cursor_row_d = last_row;
                walk_row_d   = last_row;
                walk_kind_d  = WK_SCROLL;
              end else begin
                cursor_row_d = row_inc[RowW-1:0];
                state_d      = ST_FINISH;
              end
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Geometry write homes the cursor and the scroll
    if (cfg_fire) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_COLS: begin
          cols_d       = cfg_data_i;
          cursor_col_d = '0;
          cursor_row_d = '0;
          offset_d     = '0;
        end
        REG_ROWS: begin
          rows_d       = cfg_data_i[CfgRowsW-1:0];
          cursor_col_d = '0;
          cursor_row_d = '0;
          offset_d     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cols_q       <= ColsReset;
      rows_q       <= RowsReset;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      offset_q     <= '0;
      walk_col_q   <= '0;
      walk_row_q   <= '0;
      walk_kind_q  <= WK_FILL;
      walk_ch_q    <= '0;
      clr_cnt_q    <= '0;
      rd_ok_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cols_q       <= cols_d;
      rows_q       <= rows_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      offset_q     <= offset_d;
      walk_col_q   <= walk_col_d;
      walk_row_q   <= walk_row_d;
      walk_kind_q  <= walk_kind_d;
      walk_ch_q    <= walk_ch_d;
      clr_cnt_q    <= clr_cnt_d;
      rd_ok_q      <= rd_ok_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_e'(mode_i);
      ch_q    <= char_code_i;
      color_q <= color_rgb_i;
      pc_q    <= pos_col_i;
      pr_q    <= pos_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_col_q   <= OutColW'(cursor_col_q);
      out_row_q   <= OutRowW'(cursor_row_q);
      out_ch_q    <= rd_ok_q ? rd_data_q.ch : '0;
      out_color_q <= rd_ok_q ? rd_data_q.color : '0;
      out_rd_ok_q <= rd_ok_q;
    end
  end

  // Cell store, single port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign read_char_o  = out_ch_q;
  assign read_color_o = out_color_q;
  assign read_valid_o = out_rd_ok_q;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("item accepted during store clear");

  a_cursor_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cursor_col_q} < cols_a) && ({1'b0, cursor_row_q} < rows_a))
    else $error("cursor outside active screen");

  a_offset_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, offset_q} < rows_a)
    else $error("scroll offset outside active rows");

  a_idle_no_store_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_FINISH) |-> !mem_we && !mem_re)
    else $error("store access while no item in work");

  a_read_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !read_valid_o) |-> (read_char_o == '0) && (read_color_o == '0))
    else $error("read fields set without a valid read");
`endif

endmodule
